// ----- rtl/rhcvt_pkg.sv -----
// Shared types and constants for the RGB/HSV converter with hue rotation.
package rhcvt_pkg;

  typedef struct packed {
    logic [15:0] chan_a;
    logic [7:0]  chan_b;
    logic [7:0]  chan_c;
    logic [7:0]  alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [8:0] res_a;
    logic [7:0] res_b;
    logic [7:0] res_c;
    logic [7:0] alpha_out;
  } pix_out_t;

  typedef enum logic [1:0] {
    MODE_TO_HSV = 2'd0,
    MODE_TO_RGB = 2'd1,
    MODE_ROTATE = 2'd2,
    MODE_PASS   = 2'd3
  } mode_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_STEP = 1'd1;

  localparam int DIV_STAGES = 8;
  localparam int DIV_NUM_W  = 16;

  localparam int HUE_MOD  = 360;
  localparam int SECT_DEG = 60;

  // reciprocal multipliers: floor(x/360), floor(x/255), floor(x/15300)
  localparam logic [13:0] HUE_MOD_MUL  = 14'd11651;
  localparam logic [15:0] DIV255_MUL   = 16'd32897;
  localparam logic [22:0] DIV15300_MUL = 23'd4491470;

  typedef struct packed {
    pix_in_t    pix;
    logic [7:0] vmax;
    logic       neg;
    logic [8:0] base;
  } front_t;

  typedef struct packed {
    logic [8:0] h0;
    logic [7:0] s0;
    logic [7:0] v0;
    logic [7:0] rs;
    logic [7:0] rv;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [7:0] pc;
    logic [7:0] alpha;
  } back_t;

endpackage

// ----- rtl/rhcvt_div.sv -----
// Pipelined restoring dividers for saturation and hue, one quotient bit per stage.
module rhcvt_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  rhcvt_pkg::front_t                   in_side,
  input  logic [rhcvt_pkg::DIV_NUM_W-1:0]     sat_num,
  input  logic [7:0]                          sat_den,
  input  logic [rhcvt_pkg::DIV_NUM_W-1:0]     hue_num,
  input  logic [7:0]                          hue_den,
  output logic                                out_vld,
  output rhcvt_pkg::front_t                   out_side,
  output logic [rhcvt_pkg::DIV_STAGES-1:0]    sat_quo,
  output logic [rhcvt_pkg::DIV_STAGES-1:0]    hue_quo
);
  localparam int NS = rhcvt_pkg::DIV_STAGES;
  localparam int NW = rhcvt_pkg::DIV_NUM_W;
  localparam int TW = NW + NS;

  logic              vld_r  [NS];
  rhcvt_pkg::front_t side_r [NS];
  logic [NW-1:0]     srem_r [NS];
  logic [NW-1:0]     hrem_r [NS];
  logic [7:0]        sden_r [NS];
  logic [7:0]        hden_r [NS];
  logic [NS-1:0]     squo_r [NS];
  logic [NS-1:0]     hquo_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = NS - 1 - k;
    logic              pv;
    rhcvt_pkg::front_t pside;
    logic [NW-1:0]     psrem, phrem, srem_nxt, hrem_nxt;
    logic [7:0]        psden, phden;
    logic [NS-1:0]     psquo, phquo, squo_nxt, hquo_nxt;
    logic [TW-1:0]     strial, htrial;

    if (k == 0) begin : g_first
      assign pv    = in_vld;
      assign pside = in_side;
      assign psrem = sat_num;
      assign phrem = hue_num;
      assign psden = sat_den;
      assign phden = hue_den;
      assign psquo = '0;
      assign phquo = '0;
    end else begin : g_next
      assign pv    = vld_r[k-1];
      assign pside = side_r[k-1];
      assign psrem = srem_r[k-1];
      assign phrem = hrem_r[k-1];
      assign psden = sden_r[k-1];
      assign phden = hden_r[k-1];
      assign psquo = squo_r[k-1];
      assign phquo = hquo_r[k-1];
    end

    always_comb begin
      strial   = TW'(psden) << B;
      htrial   = TW'(phden) << B;
      srem_nxt = psrem;
      hrem_nxt = phrem;
      squo_nxt = psquo;
      hquo_nxt = phquo;
      if (TW'(psrem) >= strial) begin
        srem_nxt    = psrem - NW'(strial);
        squo_nxt[B] = 1'b1;
      end
      if (TW'(phrem) >= htrial) begin
        hrem_nxt    = phrem - NW'(htrial);
        hquo_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= pside;
        srem_r[k] <= srem_nxt;
        hrem_r[k] <= hrem_nxt;
        sden_r[k] <= psden;
        hden_r[k] <= phden;
        squo_r[k] <= squo_nxt;
        hquo_r[k] <= hquo_nxt;
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_side = side_r[NS-1];
  assign sat_quo  = squo_r[NS-1];
  assign hue_quo  = hquo_r[NS-1];

endmodule

// ----- rtl/rhcvt_rgb.sv -----
// HSV to RGB back end: hue modulo 360, sector split, reciprocal divides, output mux.
module rhcvt_rgb (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  rhcvt_pkg::mode_t    mode,
  input  logic                in_vld,
  input  rhcvt_pkg::back_t    in_bk,
  input  logic [16:0]         in_hue,
  output logic                out_vld,
  output rhcvt_pkg::pix_out_t out_pix
);
  logic              b1_vld_r, b2_vld_r, b3_vld_r, b4_vld_r, b5_vld_r, out_vld_r;
  rhcvt_pkg::back_t  b1_bk_r, b2_bk_r, b3_bk_r, b4_bk_r, b5_bk_r;
  logic [16:0]       b1_hue_r;
  logic [30:0]       b1_prod_r;
  logic [8:0]        b2_hh_r;
  logic [2:0]        b3_sec_r, b4_sec_r, b5_sec_r;
  logic [5:0]        b3_frac_r;
  logic [15:0]       b3_vs_r;
  logic [31:0]       b4_pm_r;
  logic [21:0]       b4_qn_r, b4_tn_r;
  logic [7:0]        b5_pdiv_r;
  logic [44:0]       b5_qm_r, b5_tm_r;
  rhcvt_pkg::pix_out_t out_pix_r;

  logic [8:0]  q360;
  logic [8:0]  hh_nxt;
  logic [2:0]  sec_nxt;
  logic [8:0]  sec_base;
  logic [5:0]  frac_nxt;
  logic [7:0]  qdiv, tdiv, pv, qv, tv, cr, cg, cb;
  rhcvt_pkg::pix_out_t pix_nxt;

  always_comb begin
    q360   = b1_prod_r[30:22];
    hh_nxt = 9'(b1_hue_r - 17'(q360) * 17'(rhcvt_pkg::HUE_MOD));
  end

  always_comb begin
    if (b2_hh_r < 9'(rhcvt_pkg::SECT_DEG)) begin
      sec_nxt = 3'd0;
    end else if (b2_hh_r < 9'(2 * rhcvt_pkg::SECT_DEG)) begin
      sec_nxt = 3'd1;
    end else if (b2_hh_r < 9'(3 * rhcvt_pkg::SECT_DEG)) begin
      sec_nxt = 3'd2;
    end else if (b2_hh_r < 9'(4 * rhcvt_pkg::SECT_DEG)) begin
      sec_nxt = 3'd3;
    end else if (b2_hh_r < 9'(5 * rhcvt_pkg::SECT_DEG)) begin
      sec_nxt = 3'd4;
    end else begin
      sec_nxt = 3'd5;
    end
    sec_base = 9'(sec_nxt) * 9'(rhcvt_pkg::SECT_DEG);
    frac_nxt = 6'(b2_hh_r - sec_base);
  end

  always_comb begin
    qdiv = b5_qm_r[43:36];
    tdiv = b5_tm_r[43:36];
    pv   = b5_bk_r.rv - b5_pdiv_r;
    qv   = b5_bk_r.rv - qdiv;
    tv   = b5_bk_r.rv - tdiv;
    case (b5_sec_r)
      3'd0: begin cr = b5_bk_r.rv; cg = tv; cb = pv; end
      3'd1: begin cr = qv; cg = b5_bk_r.rv; cb = pv; end
      3'd2: begin cr = pv; cg = b5_bk_r.rv; cb = tv; end
      3'd3: begin cr = pv; cg = qv; cb = b5_bk_r.rv; end
      3'd4: begin cr = tv; cg = pv; cb = b5_bk_r.rv; end
      default: begin cr = b5_bk_r.rv; cg = pv; cb = qv; end
    endcase
    if (b5_bk_r.rs == 8'd0 || b5_bk_r.rv == 8'd0) begin
      cr = b5_bk_r.rv;
      cg = b5_bk_r.rv;
      cb = b5_bk_r.rv;
    end
    pix_nxt.alpha_out = b5_bk_r.alpha;
    case (mode)
      rhcvt_pkg::MODE_TO_HSV: begin
        pix_nxt.res_a = b5_bk_r.h0;
        pix_nxt.res_b = b5_bk_r.s0;
        pix_nxt.res_c = b5_bk_r.v0;
      end
      rhcvt_pkg::MODE_TO_RGB, rhcvt_pkg::MODE_ROTATE: begin
        pix_nxt.res_a = {1'b0, cr};
        pix_nxt.res_b = cg;
        pix_nxt.res_c = cb;
      end
      default: begin
        pix_nxt.res_a = {1'b0, b5_bk_r.pa};
        pix_nxt.res_b = b5_bk_r.pb;
        pix_nxt.res_c = b5_bk_r.pc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r  <= 1'b0;
      b2_vld_r  <= 1'b0;
      b3_vld_r  <= 1'b0;
      b4_vld_r  <= 1'b0;
      b5_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      b1_vld_r  <= in_vld;
      b2_vld_r  <= b1_vld_r;
      b3_vld_r  <= b2_vld_r;
      b4_vld_r  <= b3_vld_r;
      b5_vld_r  <= b4_vld_r;
      out_vld_r <= b5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_bk_r   <= in_bk;
      b1_hue_r  <= in_hue;
      b1_prod_r <= 31'(in_hue) * 31'(rhcvt_pkg::HUE_MOD_MUL);
      b2_bk_r   <= b1_bk_r;
      b2_hh_r   <= hh_nxt;
      b3_bk_r   <= b2_bk_r;
      b3_sec_r  <= sec_nxt;
      b3_frac_r <= frac_nxt;
      b3_vs_r   <= 16'(b2_bk_r.rv) * 16'(b2_bk_r.rs);
      b4_bk_r   <= b3_bk_r;
      b4_sec_r  <= b3_sec_r;
      b4_pm_r   <= 32'(b3_vs_r) * 32'(rhcvt_pkg::DIV255_MUL);
      b4_qn_r   <= 22'(b3_vs_r) * 22'(b3_frac_r);
      b4_tn_r   <= 22'(b3_vs_r) * 22'(6'(rhcvt_pkg::SECT_DEG) - b3_frac_r);
      b5_bk_r   <= b4_bk_r;
      b5_sec_r  <= b4_sec_r;
      b5_pdiv_r <= b4_pm_r[30:23];
      b5_qm_r   <= 45'(b4_qn_r) * 45'(rhcvt_pkg::DIV15300_MUL);
      b5_tm_r   <= 45'(b4_tn_r) * 45'(rhcvt_pkg::DIV15300_MUL);
      out_pix_r <= pix_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign out_pix = out_pix_r;

endmodule

// ----- rtl/rgb_hsv_convert_hue_rotate.sv -----
// Top level: pixel converter between RGB and HSV with hue rotation.
//
// Usage:
//   in_valid/in_ready carry one pixel word (chan_a, chan_b, chan_c, alpha_in);
//   out_valid/out_ready carry one result word (res_a, res_b, res_c, alpha_out).
//   cfg_we writes cfg_data to register cfg_index: 0 mode, 1 hue_step.
//   Write configuration only while no word is in flight.
// Timing:
//   From input accept to output valid a word passes one front stage, eight
//   stages of the saturation/hue dividers (one quotient bit each), one hue
//   stage and six back-end stages (modulo 360, sector, reciprocal multiplies,
//   output register). One word is accepted every cycle while not stalled.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline and sets mode and
//   hue_step to zero.
// Stall:
//   While out_valid is high and out_ready low, the whole pipeline holds and
//   in_ready is low; no word is dropped or repeated.
module rgb_hsv_convert_hue_rotate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rhcvt_pkg::pix_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rhcvt_pkg::pix_out_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [rhcvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rhcvt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  logic                   adv;
  rhcvt_pkg::mode_t       mode_r;
  logic [15:0]            hue_step_r;

  logic                   f_vld_r;
  rhcvt_pkg::front_t      f_side_r;
  logic [15:0]            f_snum_r, f_hnum_r;
  logic [7:0]             f_sden_r, f_hden_r;

  logic                   d_vld;
  rhcvt_pkg::front_t      d_side;
  logic [7:0]             d_sq, d_hq;

  logic                   h_vld_r;
  rhcvt_pkg::back_t       h_bk_r;
  logic [16:0]            h_hue_r;

  logic                   o_vld;
  rhcvt_pkg::pix_out_t    o_pix;

  logic [7:0]             r, g, b, mx, mn, delta, d1, d2, mag;
  rhcvt_pkg::front_t      side_nxt;
  logic [15:0]            snum_nxt, hnum_nxt;

  logic [7:0]             s0;
  logic [9:0]             hsum;
  logic [8:0]             h0;
  rhcvt_pkg::back_t       bk_nxt;
  logic [16:0]            hue_nxt;

  assign adv      = !o_vld || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= rhcvt_pkg::MODE_TO_HSV;
      hue_step_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rhcvt_pkg::CFG_MODE:     mode_r <= rhcvt_pkg::mode_t'(cfg_data[1:0]);
        rhcvt_pkg::CFG_HUE_STEP: hue_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: max, min, sector base and the two dividends
  always_comb begin
    r  = in_data.chan_a[7:0];
    g  = in_data.chan_b;
    b  = in_data.chan_c;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    side_nxt.pix  = in_data;
    side_nxt.vmax = mx;
    if (r == mx) begin
      side_nxt.base = 9'd0;
      d1 = g;
      d2 = b;
    end else if (g == mx) begin
      side_nxt.base = 9'd120;
      d1 = b;
      d2 = r;
    end else begin
      side_nxt.base = 9'd240;
      d1 = r;
      d2 = g;
    end
    side_nxt.neg = d1 < d2;
    mag      = side_nxt.neg ? d2 - d1 : d1 - d2;
    hnum_nxt = (16'(mag) << 6) - (16'(mag) << 2);
    snum_nxt = (16'(delta) << 8) - 16'(delta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side_r <= side_nxt;
      f_snum_r <= snum_nxt;
      f_hnum_r <= hnum_nxt;
      f_sden_r <= mx;
      f_hden_r <= delta;
    end
  end

  rhcvt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (f_vld_r),
    .in_side  (f_side_r),
    .sat_num  (f_snum_r),
    .sat_den  (f_sden_r),
    .hue_num  (f_hnum_r),
    .hue_den  (f_hden_r),
    .out_vld  (d_vld),
    .out_side (d_side),
    .sat_quo  (d_sq),
    .hue_quo  (d_hq)
  );

  // hue finish and rotation select
  always_comb begin
    s0   = (d_side.vmax == 8'd0) ? 8'd0 : d_sq;
    hsum = d_side.neg ? 10'(d_side.base) - 10'(d_hq) : 10'(d_side.base) + 10'(d_hq);
    if (hsum[9]) hsum = hsum + 10'(rhcvt_pkg::HUE_MOD);
    h0   = (s0 == 8'd0) ? 9'd0 : hsum[8:0];
    bk_nxt.h0    = h0;
    bk_nxt.s0    = s0;
    bk_nxt.v0    = d_side.vmax;
    bk_nxt.pa    = d_side.pix.chan_a[7:0];
    bk_nxt.pb    = d_side.pix.chan_b;
    bk_nxt.pc    = d_side.pix.chan_c;
    bk_nxt.alpha = d_side.pix.alpha_in;
    if (mode_r == rhcvt_pkg::MODE_TO_RGB) begin
      bk_nxt.rs = d_side.pix.chan_b;
      bk_nxt.rv = d_side.pix.chan_c;
      hue_nxt   = {1'b0, d_side.pix.chan_a};
    end else begin
      bk_nxt.rs = s0;
      bk_nxt.rv = d_side.vmax;
      hue_nxt   = 17'(h0) + 17'(hue_step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (adv) begin
      h_vld_r <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_bk_r  <= bk_nxt;
      h_hue_r <= hue_nxt;
    end
  end

  rhcvt_rgb u_rgb (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .mode    (mode_r),
    .in_vld  (h_vld_r),
    .in_bk   (h_bk_r),
    .in_hue  (h_hue_r),
    .out_vld (o_vld),
    .out_pix (o_pix)
  );

  assign out_valid = o_vld;
  assign out_data  = o_pix;

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.res_a < 9'd360)
    else $error("res_a out of range");
  a_rgb_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r != rhcvt_pkg::MODE_TO_HSV |-> !out_data.res_a[8])
    else $error("rgb red wider than 8 bits");
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r == rhcvt_pkg::MODE_TO_HSV && out_data.res_b == 8'd0
    |-> out_data.res_a == 9'd0)
    else $error("zero saturation with nonzero hue");
`endif

endmodule
